>>> sv/btn_db_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button debounce and press detection block.
// No dependencies; used by every module of the block.
package btn_db_pkg;

    localparam int BUTTON_COUNT = 4;
    localparam int OUT_W        = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(25);
    localparam logic [CFG_W-1:0] LONG_RESET     = CFG_W'(600);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 8'd0,
        REG_LONG     = 8'd1
    } cfg_reg_t;

    // What one lane found for the current poll
    typedef struct packed {
        logic long_ev;
        logic press_acc;
        logic short_ev;
        logic level_next;
    } lane_flags_t;

    typedef struct packed {
        logic [OUT_W-1:0] short_press;
        logic [OUT_W-1:0] long_press;
        logic [OUT_W-1:0] stable_down;
        logic             activity;
        logic             wake;
    } result_t;

endpackage

>>> sv/button_debounce_short_long_press_core.sv
`timescale 1ns / 1ps
// Top level of the button debounce block with short and long press detection.
// Depends on btn_db_pkg, btn_db_lane and btn_db_merge.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   poll    | s_valid s_ready s_now_ms s_raw_down     | in
//           | s_wake_only                             |
//   result  | m_valid m_ready m_short_press           | out
//           | m_long_press m_stable_down m_activity   |
//           | m_wake                                  |
//   config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// One poll per cycle while the result side is not stalled; each result appears in the cycle after its poll is taken.
// Per-button lanes each do a 32-bit subtract and compare; the merging stage
// then runs the one-bit sleep chain across the lanes.
// Reset (aresetn low, synchronous) clears all button state and loads
// debounce 25 ms and long press 600 ms.
// A stalled result holds in the output register; a new poll is taken in the
// same cycle that the waiting word leaves.
module button_debounce_short_long_press_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [btn_db_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [3:0]                           s_raw_down,
    input  logic                                 s_wake_only,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [btn_db_pkg::OUT_W-1:0]         m_short_press,
    output logic [btn_db_pkg::OUT_W-1:0]         m_long_press,
    output logic [btn_db_pkg::OUT_W-1:0]         m_stable_down,
    output logic                                 m_activity,
    output logic                                 m_wake,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [btn_db_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [btn_db_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [btn_db_pkg::CFG_W-1:0]  debounce_reg;
    logic [btn_db_pkg::CFG_W-1:0]  long_reg;
    logic                          m_valid_reg;
    btn_db_pkg::result_t           result_reg;
    btn_db_pkg::result_t           result_next;
    logic                          accept;

    btn_db_pkg::lane_flags_t [btn_db_pkg::BUTTON_COUNT-1:0] flags;
    logic [btn_db_pkg::BUTTON_COUNT-1:0]                    consume;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= btn_db_pkg::DEBOUNCE_RESET;
            long_reg     <= btn_db_pkg::LONG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                btn_db_pkg::REG_DEBOUNCE: begin
                    debounce_reg <= cfg_data[btn_db_pkg::CFG_W-1:0];
                end
                btn_db_pkg::REG_LONG: begin
                    long_reg <= cfg_data[btn_db_pkg::CFG_W-1:0];
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    for (genvar g = 0; g < btn_db_pkg::BUTTON_COUNT; g++) begin : g_lane
        logic down;
        if (g < 4) begin : g_raw
            assign down = s_raw_down[g];
        end else begin : g_none
            assign down = 1'b0;
        end

        btn_db_lane u_lane (
            .aclk            (aclk),
            .aresetn         (aresetn),
            .accept          (accept),
            .now_ms          (s_now_ms),
            .down            (down),
            .debounce_time   (debounce_reg),
            .long_press_time (long_reg),
            .consume         (consume[g]),
            .flags           (flags[g])
        );
    end

    btn_db_merge u_merge (
        .wake_only (s_wake_only),
        .flags     (flags),
        .consume   (consume),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_short_press = result_reg.short_press;
    assign m_long_press  = result_reg.long_press;
    assign m_stable_down = result_reg.stable_down;
    assign m_activity    = result_reg.activity;
    assign m_wake        = result_reg.wake;

    a_wake_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_wake || m_activity))
        else $error("wake without activity");

    a_short_long_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_short_press & m_long_press) == '0))
        else $error("short and long press on the same button");

    a_short_released: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_short_press & m_stable_down) == '0))
        else $error("short press on a button still down");

    a_long_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_long_press & ~m_stable_down) == '0))
        else $error("long press on a released button");

endmodule

>>> sv/btn_db_lane.sv
`timescale 1ns / 1ps
// One button lane: debounced level, change and press timestamps, long-fired mark.
// Depends on btn_db_pkg.
module btn_db_lane (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  logic [btn_db_pkg::TIME_W-1:0]    now_ms,
    input  logic                             down,
    input  logic [btn_db_pkg::CFG_W-1:0]     debounce_time,
    input  logic [btn_db_pkg::CFG_W-1:0]     long_press_time,
    input  logic                             consume,
    output btn_db_pkg::lane_flags_t          flags
);

    logic                            level_reg;
    logic                            fired_reg;
    logic [btn_db_pkg::TIME_W-1:0]   start_reg;
    logic [btn_db_pkg::TIME_W-1:0]   change_reg;

    logic                            same;
    logic                            chg_ok;
    logic [btn_db_pkg::TIME_W-1:0]   held;
    logic [btn_db_pkg::TIME_W-1:0]   since;

    assign same  = (down == level_reg);
    assign held  = now_ms - start_reg;
    assign since = now_ms - change_reg;
    assign chg_ok = !same &&
        (since >= {{(btn_db_pkg::TIME_W-btn_db_pkg::CFG_W){1'b0}}, debounce_time});

    assign flags.long_ev = same && down && !fired_reg &&
        (held >= {{(btn_db_pkg::TIME_W-btn_db_pkg::CFG_W){1'b0}}, long_press_time});
    assign flags.press_acc  = chg_ok && down;
    assign flags.short_ev   = chg_ok && !down && !fired_reg;
    assign flags.level_next = chg_ok ? down : level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= 1'b0;
            fired_reg  <= 1'b0;
            start_reg  <= '0;
            change_reg <= '0;
        end else if (accept) begin
            if (flags.long_ev) begin
                fired_reg <= 1'b1;
            end
            if (chg_ok) begin
                change_reg <= now_ms;
                level_reg  <= down;
                if (down) begin
                    start_reg <= now_ms;
                    // a press taken as a display wake counts as already fired
                    fired_reg <= consume;
                end
            end
        end
    end

endmodule

>>> sv/btn_db_merge.sv
`timescale 1ns / 1ps
// Merging stage: walks the sleep state through the lanes in index order and
// folds the lane flags into one result word. Depends on btn_db_pkg.
module btn_db_merge (
    input  logic                                              wake_only,
    input  btn_db_pkg::lane_flags_t [btn_db_pkg::BUTTON_COUNT-1:0] flags,
    output logic [btn_db_pkg::BUTTON_COUNT-1:0]               consume,
    output btn_db_pkg::result_t                               result
);

    logic [btn_db_pkg::BUTTON_COUNT-1:0] shorts;
    logic [btn_db_pkg::BUTTON_COUNT-1:0] longs;
    logic [btn_db_pkg::BUTTON_COUNT-1:0] levels;
    logic [btn_db_pkg::BUTTON_COUNT-1:0] presses;

    always_comb begin
        logic asleep;
        asleep = wake_only;
        for (int i = 0; i < btn_db_pkg::BUTTON_COUNT; i++) begin
            consume[i] = asleep && flags[i].press_acc;
            shorts[i]  = flags[i].short_ev;
            longs[i]   = flags[i].long_ev;
            levels[i]  = flags[i].level_next;
            presses[i] = flags[i].press_acc;
            // sleep ends at the first consumed press or reported short press
            if (consume[i] || flags[i].short_ev) begin
                asleep = 1'b0;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < btn_db_pkg::OUT_W; j++) begin
            if (j < btn_db_pkg::BUTTON_COUNT) begin
                result.short_press[j] = shorts[j];
                result.long_press[j]  = longs[j];
                result.stable_down[j] = levels[j];
            end else begin
                result.short_press[j] = 1'b0;
                result.long_press[j]  = 1'b0;
                result.stable_down[j] = 1'b0;
            end
        end
        result.activity = (|longs) || (|presses);
        result.wake     = |consume;
    end

endmodule

>>> tb/sv/press_event_checker.sv
`timescale 1ns / 1ps
// Checker for the button debounce core: watches the poll, result and register channels,
// predicts each result word from its own copy of the button state and compares field by field.
// Depends on btn_db_pkg.
module press_event_checker
    import btn_db_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [TIME_W-1:0]      s_now_ms,
    input  logic [3:0]             s_raw_down,
    input  logic                   s_wake_only,

    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [OUT_W-1:0]       m_short_press,
    input  logic [OUT_W-1:0]       m_long_press,
    input  logic [OUT_W-1:0]       m_stable_down,
    input  logic                   m_activity,
    input  logic                   m_wake,

    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    output int                     errors,
    output int                     pending
);

    logic [CFG_W-1:0]        settle_ms;
    logic [CFG_W-1:0]        long_ms;
    logic [BUTTON_COUNT-1:0] level_q;
    logic [BUTTON_COUNT-1:0] fired_q;
    logic [TIME_W-1:0]       pressed_at [BUTTON_COUNT];
    logic [TIME_W-1:0]       changed_at [BUTTON_COUNT];

    result_t expected_events [$];

    initial begin
        errors  = 0;
        pending = 0;
    end

    // Advance the button state by one poll and return the word it should produce
    function automatic result_t poll_buttons(input logic [TIME_W-1:0] now,
                                             input logic [3:0] raw,
                                             input logic sleeping);
        result_t           r;
        logic              asleep;
        logic              down;
        logic [TIME_W-1:0] since;
        r      = '0;
        asleep = sleeping;
        for (int b = 0; b < BUTTON_COUNT; b++) begin
            down = (b < 4) ? raw[b] : 1'b0;
            if (down == level_q[b]) begin
                since = now - pressed_at[b];
                if (down && !fired_q[b] && since >= TIME_W'(long_ms)) begin
                    fired_q[b] = 1'b1;
                    if (b < OUT_W) r.long_press[b] = 1'b1;
                    r.activity = 1'b1;
                end
            end else begin
                since = now - changed_at[b];
                if (since >= TIME_W'(settle_ms)) begin
                    changed_at[b] = now;
                    level_q[b]    = down;
                    if (down) begin
                        pressed_at[b] = now;
                        fired_q[b]    = 1'b0;
                        r.activity    = 1'b1;
                        // first press while asleep only wakes the display
                        if (asleep) begin
                            asleep     = 1'b0;
                            r.wake     = 1'b1;
                            fired_q[b] = 1'b1;
                        end
                    end else if (!fired_q[b]) begin
                        if (b < OUT_W) r.short_press[b] = 1'b1;
                        asleep = 1'b0;
                    end
                end
            end
        end
        for (int b = 0; b < BUTTON_COUNT && b < OUT_W; b++)
            r.stable_down[b] = level_q[b];
        return r;
    endfunction

    task automatic compare_field(input string label, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, got %h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            settle_ms = DEBOUNCE_RESET;
            long_ms   = LONG_RESET;
            level_q   = '0;
            fired_q   = '0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                pressed_at[b] = '0;
                changed_at[b] = '0;
            end
            expected_events.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE: settle_ms = cfg_data[CFG_W-1:0];
                    REG_LONG:     long_ms   = cfg_data[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t ns: result word with none expected, got %h %h %h %b %b",
                             $time, m_short_press, m_long_press, m_stable_down,
                             m_activity, m_wake);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    compare_field("short_press", want.short_press, m_short_press);
                    compare_field("long_press", want.long_press, m_long_press);
                    compare_field("stable_down", want.stable_down, m_stable_down);
                    compare_field("activity", 4'(want.activity), 4'(m_activity));
                    compare_field("wake", 4'(want.wake), 4'(m_wake));
                end
            end
            if (s_valid && s_ready)
                expected_events.push_back(poll_buttons(s_now_ms, s_raw_down, s_wake_only));
        end
        pending = expected_events.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the button debounce testbench: clock, reset, poll and register stimulus, result stalls.
// Depends on btn_db_pkg, button_debounce_short_long_press_core and press_event_checker.
module tb;
    import btn_db_pkg::*;

    localparam int LIMIT = 400000;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] LAST_SPARE_REG  = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [TIME_W-1:0]     s_now_ms;
    logic [3:0]            s_raw_down;
    logic                  s_wake_only;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_W-1:0]      m_short_press;
    logic [OUT_W-1:0]      m_long_press;
    logic [OUT_W-1:0]      m_stable_down;
    logic                  m_activity;
    logic                  m_wake;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int  errors;
    int  pending;
    int  cycles;
    logic s_took, m_took, cfg_took;
    logic burst;

    // stimulus shaping only: current register values, the poll clock and the held buttons
    int unsigned       cur_debounce;
    int unsigned       cur_long;
    logic [TIME_W-1:0] clock_ms;
    logic [3:0]        held;

    button_debounce_short_long_press_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_now_ms      (s_now_ms),
        .s_raw_down    (s_raw_down),
        .s_wake_only   (s_wake_only),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_short_press (m_short_press),
        .m_long_press  (m_long_press),
        .m_stable_down (m_stable_down),
        .m_activity    (m_activity),
        .m_wake        (m_wake),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    press_event_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_now_ms      (s_now_ms),
        .s_raw_down    (s_raw_down),
        .s_wake_only   (s_wake_only),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_short_press (m_short_press),
        .m_long_press  (m_long_press),
        .m_stable_down (m_stable_down),
        .m_activity    (m_activity),
        .m_wake        (m_wake),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // register the handshakes so the driving processes read them without races
    always @(posedge aclk) begin
        s_took   <= s_valid && s_ready;
        m_took   <= m_valid && m_ready;
        cfg_took <= cfg_valid && cfg_ready;
        cycles   <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: stall a random number of cycles before taking each word
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(negedge aclk); while (!m_took);
        end
    end

    // valid stays up between back-to-back polls, so only drop it for a real gap
    task automatic send_poll(input logic [TIME_W-1:0] t, input logic [3:0] raw,
                             input logic sleepy);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_now_ms    <= t;
        s_raw_down  <= raw;
        s_wake_only <= sleepy;
        do @(negedge aclk); while (!s_took);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge aclk);
        if (idx == REG_DEBOUNCE) cur_debounce = data[CFG_W-1:0];
        if (idx == REG_LONG) cur_long = data[CFG_W-1:0];
    endtask

    // hold until every word in flight has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    task automatic set_timing(input int unsigned deb, input int unsigned lng);
        logic [CFG_DATA_W-1:0] junk;
        junk = $urandom;
        write_reg(REG_DEBOUNCE, {junk[CFG_DATA_W-1:CFG_W], CFG_W'(deb)});
        junk = $urandom;
        write_reg(REG_LONG, {junk[CFG_DATA_W-1:CFG_W], CFG_W'(lng)});
        if ($urandom_range(0, 1))
            write_reg(CFG_IDX_W'($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG)), $urandom);
    endtask

    // mostly holds and single-button flips, with steps around the debounce and long times
    task automatic random_polls(input int count);
        int unsigned delta;
        int          pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 29) == 0) burst = ~burst;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                held = held;
            else if (pick < 8)
                held = held ^ 4'(1 << $urandom_range(0, 3));
            else
                held = 4'($urandom_range(0, 15));
            pick = $urandom_range(0, 9);
            if (pick < 3)
                delta = $urandom_range(0, 2);
            else if (pick < 6)
                delta = $urandom_range(0, cur_debounce + 1);
            else
                delta = $urandom_range(0, cur_debounce + cur_long + 2);
            if ($urandom_range(0, 59) == 0)
                clock_ms = $urandom;
            else
                clock_ms = clock_ms + delta;
            send_poll(clock_ms, held, $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_now_ms    = '0;
        s_raw_down  = '0;
        s_wake_only = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycles      = 0;
        burst       = 1'b0;
        held        = '0;
        clock_ms    = '0;
        cur_debounce = 25;
        cur_long     = 600;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset timing: 25 ms debounce, 600 ms long press
        send_poll(32'd0, 4'b0000, 1'b0);
        send_poll(32'd10, 4'b0001, 1'b0);          // inside debounce, drop
        send_poll(32'd30, 4'b0001, 1'b0);          // press accepted
        send_poll(32'd40, 4'b0000, 1'b0);          // bounce, drop
        send_poll(32'd630, 4'b0001, 1'b0);         // long press fires
        send_poll(32'd700, 4'b0001, 1'b0);         // no second long
        send_poll(32'd710, 4'b0000, 1'b0);         // release after long, no short
        send_poll(32'd800, 4'b1111, 1'b1);         // first press wakes, rest count
        send_poll(32'd900, 4'b0000, 1'b0);
        send_poll(32'd1000, 4'b0010, 1'b0);
        send_poll(32'd1100, 4'b0100, 1'b1);        // short release ends sleep first
        send_poll(32'd1200, 4'b0000, 1'b0);
        send_poll(32'd1300, 4'b1000, 1'b1);        // consumed press
        send_poll(32'd2000, 4'b1000, 1'b0);        // consumed: no long
        send_poll(32'd2100, 4'b0000, 1'b0);        // consumed: no short
        send_poll(32'hFFFF_FFF0, 4'b0001, 1'b0);
        send_poll(32'h0000_0100, 4'b0001, 1'b0);   // wrapped, still short of long
        send_poll(32'h0000_0300, 4'b0001, 1'b0);
        send_poll(32'hFFFF_FFFF, 4'b1110, 1'b0);
        send_poll(32'hFFFF_FFFF, 4'b0000, 1'b1);
        send_poll(32'h0000_0300, 4'b1110, 1'b1);   // three longs in one poll
        drain();

        set_timing(0, 0);
        write_reg(FIRST_SPARE_REG, '1);
        write_reg(LAST_SPARE_REG, $urandom);
        send_poll(32'h0000_0400, 4'b0000, 1'b0);
        send_poll(32'h0000_0400, 4'b0001, 1'b0);
        send_poll(32'h0000_0400, 4'b0001, 1'b0);   // zero long time fires at once
        send_poll(32'h0000_0400, 4'b0000, 1'b0);
        drain();

        clock_ms = 32'h0000_0400;
        held     = '0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_timing(3, 40);
                1: set_timing(65535, 65535);
                2: set_timing(0, 0);
                3: set_timing(20, 300);
                4: set_timing($urandom_range(0, 65535), $urandom_range(0, 65535));
                default: set_timing(25, 600);
            endcase
            if ($urandom_range(0, 1))
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            random_polls(105);
            drain();
        end

        repeat (10) @(negedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
sv/btn_db_pkg.sv
sv/btn_db_lane.sv
sv/btn_db_merge.sv
sv/button_debounce_short_long_press_core.sv
tb/sv/press_event_checker.sv
tb/sv/tb.sv
